// ===== rtl/core/lkvc_pkg.sv =====
// lkvc_pkg: shared types and constants of the LRU key/value cache.
// Used by lkvc_ctrl, lkvc_dp, lru_key_value_cache_top and lkvc_checker; depends on nothing.
`default_nettype none

package lkvc_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_UPDATE
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic issue_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/lkvc_ctrl.sv =====
// lkvc_ctrl: sequencer for one request (accept, key scan, update, result).
// Depends on lkvc_pkg; drives commands into lkvc_dp.
`default_nettype none

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.issue_last) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.start = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_TAIL: begin
        cmd_o = '0;
      end
      ST_UPDATE: begin
        cmd_o.update = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/lkvc_dp.sv =====
// lkvc_dp: key/value memories, valid bits, recency ranks, capacity register
// and result register. Depends on lkvc_pkg; commanded by lkvc_ctrl.
`default_nettype none

module lkvc_dp
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  logic             in_func_i,
  input  logic [KEY_W-1:0] in_key_i,
  input  logic [VAL_W-1:0] in_value_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             out_found_o,
  output logic [VAL_W-1:0] out_read_value_o,
  output logic             out_evicted_o,
  output logic [KEY_W-1:0] out_evicted_key_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [KEY_W-1:0]  key_mem [ENTRIES];
  logic [VAL_W-1:0]  val_mem [ENTRIES];

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [RANK_W-1:0]  rank_q [ENTRIES];
  logic [RANK_W-1:0]  rank_d [ENTRIES];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CAP_W-1:0]   cap_q;

  logic             req_func_q;
  logic [KEY_W-1:0] req_key_q;
  logic [VAL_W-1:0] req_val_q;

  logic [IDX_W-1:0] idx_q;
  logic             rd_pend_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [KEY_W-1:0] key_rd_q;
  logic [VAL_W-1:0] val_rd_q;

  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic [RANK_W-1:0] hit_rank_q;
  logic [VAL_W-1:0]  hit_val_q;
  logic              free_q;
  logic [IDX_W-1:0]  free_idx_q;
  logic [IDX_W-1:0]  vic_idx_q;
  logic [KEY_W-1:0]  vic_key_q;

  logic             out_valid_q;
  logic             out_found_q;
  logic [VAL_W-1:0] out_rd_q;
  logic             out_ev_q;
  logic [KEY_W-1:0] out_evk_q;

  logic [RANK_W-1:0]  lru_rank;
  logic [ENTRIES-1:0] lru_vec;
  logic               rd_match;
  logic [CMP_W-1:0]   cap_ext, eff_cap;
  logic               full;
  logic               do_ins, do_evict, do_promote;
  logic [IDX_W-1:0]   sel_idx;
  logic [RANK_W-1:0]  sel_rank;
  logic [IDX_W-1:0]   wr_idx;

  // ranks of valid entries are 0 .. count-1, so the oldest holds count-1
  assign lru_rank = RANK_W'(count_q - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lru_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
    end
  end

  assign rd_match = valid_q[rd_idx_q] && (key_rd_q == req_key_q);

  assign cap_ext = CMP_W'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full       = !(CMP_W'(count_q) < eff_cap);
  assign do_ins     = (req_func_q == FUNC_PUT) && !hit_q && !full;
  assign do_evict   = (req_func_q == FUNC_PUT) && !hit_q && full;
  assign do_promote = hit_q || do_evict;
  assign sel_idx    = do_evict ? vic_idx_q : hit_idx_q;
  assign sel_rank   = do_evict ? lru_rank : hit_rank_q;
  assign wr_idx     = do_ins ? free_idx_q : sel_idx;

  assign status_o.issue_last = (idx_q == IDX_W'(ENTRIES - 1));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      key_rd_q <= key_mem[idx_q];
      val_rd_q <= val_mem[idx_q];
    end
    if (cmd_i.update && (do_ins || do_evict)) begin
      key_mem[wr_idx] <= req_key_q;
    end
    if (cmd_i.update && (req_func_q == FUNC_PUT)) begin
      val_mem[wr_idx] <= req_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_func_q <= in_func_i;
      req_key_q  <= in_key_i;
      req_val_q  <= in_value_i;
    end
    if (cmd_i.scan) begin
      rd_idx_q <= idx_q;
    end
    if (rd_pend_q) begin
      if (rd_match) begin
        hit_idx_q  <= rd_idx_q;
        hit_rank_q <= rank_q[rd_idx_q];
        hit_val_q  <= val_rd_q;
      end
      if (!valid_q[rd_idx_q] && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
      if (lru_vec[rd_idx_q]) begin
        vic_idx_q <= rd_idx_q;
        vic_key_q <= key_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan;
      if (cmd_i.start) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.scan && !status_o.issue_last) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        if (rd_pend_q && rd_match) begin
          hit_q <= 1'b1;
        end
        if (rd_pend_q && !valid_q[rd_idx_q]) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (do_ins && valid_q[i]) begin
        rank_d[i] = rank_q[i] + RANK_W'(1);
      end
      if (do_promote && valid_q[i] && (rank_q[i] < sel_rank)) begin
        rank_d[i] = rank_q[i] + RANK_W'(1);
      end
    end
    if (do_ins) begin
      valid_d[free_idx_q] = 1'b1;
      rank_d[free_idx_q]  = '0;
      count_d             = count_q + CNT_W'(1);
    end
    if (do_promote) begin
      rank_d[sel_idx] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_found_q <= hit_q;
      out_ev_q    <= do_evict;
      out_evk_q   <= do_evict ? vic_key_q : '0;
      if (req_func_q == FUNC_PUT) begin
        out_rd_q <= '0;
      end else begin
        out_rd_q <= hit_q ? hit_val_q : MISS_VALUE;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_found_o       = out_found_q;
  assign out_read_value_o  = out_rd_q;
  assign out_evicted_o     = out_ev_q;
  assign out_evicted_key_o = out_evk_q;

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_value_cache_top.sv =====
// lru_key_value_cache_top: fully associative key/value cache, LRU replacement.
// An accepted request is scanned one entry a cycle through the single read port
// of the key/value memories, then passes the tail and update states; the result
// loads when update sees the output free. No new request is taken before that.
// Reset: valid bits, ranks and count cleared at once; capacity returns to 16.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_dp.
`default_nettype none

module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CAP_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    in_func_i,
  input  logic signed [KEY_W-1:0] in_key_i,
  input  logic signed [VAL_W-1:0] in_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    out_found_o,
  output logic signed [VAL_W-1:0] out_read_value_o,
  output logic                    out_evicted_o,
  output logic signed [KEY_W-1:0] out_evicted_key_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lkvc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .in_func_i         (in_func_i),
    .in_key_i          (in_key_i),
    .in_value_i        (in_value_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_found_o       (out_found_o),
    .out_read_value_o  (out_read_value_o),
    .out_evicted_o     (out_evicted_o),
    .out_evicted_key_o (out_evicted_key_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lkvc_checker.sv =====
// lkvc_checker: port-level checks of the LRU key/value cache, bound to the top.
// Depends on lkvc_pkg and lru_key_value_cache_top.
`default_nettype none

module lkvc_checker
  import lkvc_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic                    out_found_o,
  input logic signed [VAL_W-1:0] out_read_value_o,
  input logic                    out_evicted_o,
  input logic signed [KEY_W-1:0] out_evicted_key_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second request taken while one in flight");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_found_o) |-> !out_evicted_o)
    else $error("eviction reported on a hit");

  a_evk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_evicted_o) |-> (out_evicted_key_o == '0))
    else $error("evicted key nonzero without eviction");

  a_evict_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_evicted_o) |-> (out_read_value_o == '0))
    else $error("eviction with nonzero read value");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);

`default_nettype wire
